// File: hdl/srsd_pkg.sv
// Shared types, constants and tables for the sliding regression steady detector.
`timescale 1ns / 1ps
package srsd_pkg;

	localparam int WINDOW_MAX  = 64;
	localparam int SAMPLE_BITS = 16;
	localparam int PTR_W       = $clog2(WINDOW_MAX);
	localparam int CNT_W       = 7;
	localparam int D_W         = 21;
	localparam int NN_W        = 13;
	localparam int TRI_W       = 11;
	localparam int SQ_OP_W     = 36;
	localparam int SQ_STEPS    = SQ_OP_W / 2;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_LIMIT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RMSE_LIMIT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_QUANT_STEP  = 3'd4;

	localparam logic OP_PUSH  = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	localparam logic [1:0] KIND_CLEAR = 2'd0;
	localparam logic [1:0] KIND_PART  = 2'd1;
	localparam logic [1:0] KIND_FULL  = 2'd2;

	typedef struct packed {
		logic                          op;
		logic signed [SAMPLE_BITS-1:0] sample;
	} req_word_t;

	typedef struct packed {
		logic               steady;
		logic               full_res;
		logic [CNT_W-1:0]   fill_count;
		logic signed [31:0] slope;
		logic [15:0]        rmse;
		logic signed [15:0] mean;
	} res_word_t;

	typedef struct packed {
		logic       accept;
		logic       prod;
		logic       update;
		logic [5:0] calc;
		logic       div_start;
		logic       sq_init;
		logic       sq_step;
		logic       fin;
		logic       load_out;
		logic [1:0] kind;
	} ctl_cmd_t;

	typedef struct packed {
		logic will_fill;
		logic div_done;
	} ctl_sts_t;

	typedef logic [D_W-1:0]   d_tab_t   [WINDOW_MAX+1];
	typedef logic [NN_W-1:0]  nn_tab_t  [WINDOW_MAX+1];
	typedef logic [TRI_W-1:0] tri_tab_t [WINDOW_MAX+1];

	function automatic d_tab_t build_d_tab();
		d_tab_t t;
		for (int i = 0; i <= WINDOW_MAX; i++) begin
			t[i] = D_W'((longint'(i) * i * (i * i - 1)) / 12);
		end
		return t;
	endfunction

	function automatic nn_tab_t build_nn_tab();
		nn_tab_t t;
		for (int i = 0; i <= WINDOW_MAX; i++) begin
			t[i] = NN_W'(i * i);
		end
		return t;
	endfunction

	function automatic tri_tab_t build_tri_tab();
		tri_tab_t t;
		for (int i = 0; i <= WINDOW_MAX; i++) begin
			t[i] = TRI_W'((i * (i - 1)) / 2);
		end
		return t;
	endfunction

	localparam d_tab_t   D_TAB   = build_d_tab();
	localparam nn_tab_t  NN_TAB  = build_nn_tab();
	localparam tri_tab_t TRI_TAB = build_tri_tab();

endpackage

// File: hdl/srsd_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
module srsd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hdl/srsd_div.sv
// Restoring unsigned divider producing one quotient bit per cycle.
`timescale 1ns / 1ps
module srsd_div #(
	parameter int NUM_W = 50,
	parameter int DEN_W = 37
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic             busy,
	output logic [NUM_W-1:0] quot,
	output logic [DEN_W-1:0] rem
);

	localparam int CW = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic [DEN_W:0]   shifted;
	logic             fits;

	assign shifted = {rem_q, quo_q[NUM_W-1]};
	assign fits    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= DEN_W'(shifted - {1'b0, den_q});
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DEN_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule

// File: hdl/srsd_dp.sv
// Datapath: configuration, sample ring, running sums, fit arithmetic and result register.
`timescale 1ns / 1ps
module srsd_dp import srsd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  req_word_t             req_word,
	input  ctl_cmd_t              cmd,
	output ctl_sts_t              sts,
	output res_word_t             res_word
);

	logic [CNT_W-1:0] wl_q;
	logic [15:0]      per_q, slim_q, rlim_q, qs_q;
	logic [CNT_W-1:0] n_eff;
	logic [15:0]      per_eff, qs_eff;
	logic [D_W-1:0]   d_n;
	logic [NN_W-1:0]  nn_n;
	logic [TRI_W-1:0] tri_n;

	logic [PTR_W-1:0]  wp_q;
	logic [CNT_W-1:0]  held_q;
	logic signed [21:0] sv_q;
	logic [36:0]        sq_q;
	logic signed [27:0] siw_q;
	logic               empty_win;

	logic signed [15:0] y_q, old_q;
	logic [15:0]        ram_rdata;
	logic [15:0]        ym, om;
	logic               full_q;
	logic [31:0]        ysq_q, osq_q;
	logic signed [23:0] wy_q;
	logic [CNT_W-1:0]   wmul;
	logic signed [21:0] old_x, y_x, sv_next, sv_less_old;
	logic signed [27:0] siw_next;
	logic [36:0]        sq_next;

	logic signed [35:0] pa_q, s_q;
	logic signed [33:0] pb_q;
	logic [36:0]        dp_q;
	logic [31:0]        qq_q, rl2_q;
	logic [43:0]        nsq_q, vv_q, var_q;
	logic [21:0]        vm, vm_q;
	logic               svneg_q;
	logic [41:0]        dd_q;
	logic [33:0]        dn2_q;
	logic [52:0]        slimdp_q, ddqlo_q, ddqhi_q;
	logic [65:0]        dn2qq_q, dn2rl_q;
	logic               sneg_q;
	logic [31:0]        sm_q;
	logic [64:0]        dv_q, num_q;
	logic [73:0]        ddqq_q;
	logic [49:0]        a_q;
	logic [63:0]        s2_q;
	logic               slp_ok_q, rms_ok_q;
	logic [67:0]        s2x12;
	logic [68:0]        numx12;

	logic [49:0] sdiv_quot;
	logic [36:0] sdiv_rem;
	logic [66:0] rdiv_quot;
	logic [23:0] mdiv_quot;
	logic        sdiv_busy, rdiv_busy, mdiv_busy;

	logic [SQ_OP_W-1:0]     sq_op_q;
	logic [SQ_STEPS-1:0]    sq_root_q;
	logic [SQ_STEPS+2:0]    sq_rem_q;
	logic [SQ_STEPS+2:0]    rem_sh, trial;

	logic [50:0] srnd_q;
	logic [15:0] rmse_q, mean_q;
	logic [18:0] msum;
	logic [16:0] mmag;
	logic [50:0] slim_sel, sval;
	res_word_t   res_next;

	assign n_eff   = (wl_q < CNT_W'(2)) ? CNT_W'(2) :
	                 (wl_q > CNT_W'(WINDOW_MAX)) ? CNT_W'(WINDOW_MAX) : wl_q;
	assign per_eff = (per_q == 16'd0) ? 16'd1000 : per_q;
	assign qs_eff  = (qs_q == 16'd0) ? 16'd16 : qs_q;
	assign d_n     = D_TAB[n_eff];
	assign nn_n    = NN_TAB[n_eff];
	assign tri_n   = TRI_TAB[n_eff];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q   <= CNT_W'(32);
			per_q  <= 16'd1000;
			slim_q <= 16'd0;
			rlim_q <= 16'd0;
			qs_q   <= 16'd16;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WINDOW_LEN:  wl_q   <= cfg_data[CNT_W-1:0];
				CFG_PERIOD:      per_q  <= cfg_data;
				CFG_SLOPE_LIMIT: slim_q <= cfg_data;
				CFG_RMSE_LIMIT:  rlim_q <= cfg_data;
				CFG_QUANT_STEP:  qs_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign empty_win = (cfg_we && cfg_index == CFG_WINDOW_LEN) ||
	                   (cmd.accept && req_word.op == OP_CLEAR);

	// Ring of raw samples; the oldest held sample sits n places behind the write pointer.
	srsd_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(WINDOW_MAX)) u_ring (
		.clk   (clk),
		.we    (cmd.update),
		.waddr (wp_q),
		.wdata (y_q),
		.re    (cmd.accept),
		.raddr (wp_q - n_eff[PTR_W-1:0]),
		.rdata (ram_rdata)
	);

	assign ym   = y_q[15] ? 16'(-y_q) : 16'(y_q);
	assign om   = ram_rdata[15] ? 16'(-ram_rdata) : ram_rdata;
	assign wmul = (held_q >= n_eff) ? n_eff - CNT_W'(1) : held_q;

	assign old_x       = 22'(old_q);
	assign y_x         = 22'(y_q);
	assign sv_less_old = sv_q - old_x;
	assign sv_next     = sv_q + y_x - (full_q ? old_x : 22'sd0);
	assign siw_next    = siw_q + 28'(wy_q) - (full_q ? 28'(sv_less_old) : 28'sd0);
	assign sq_next     = sq_q + 37'(ysq_q) - (full_q ? 37'(osq_q) : 37'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			held_q <= '0;
			sv_q   <= '0;
			sq_q   <= '0;
			siw_q  <= '0;
		end else if (empty_win) begin
			wp_q   <= '0;
			held_q <= '0;
			sv_q   <= '0;
			sq_q   <= '0;
			siw_q  <= '0;
		end else if (cmd.update) begin
			wp_q   <= wp_q + PTR_W'(1);
			held_q <= full_q ? held_q : held_q + CNT_W'(1);
			sv_q   <= sv_next;
			sq_q   <= sq_next;
			siw_q  <= siw_next;
		end
	end

	assign sts.will_fill = full_q || (held_q + CNT_W'(1) == n_eff);

	assign vm = sv_q[21] ? 22'(-sv_q) : 22'(sv_q);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			y_q <= req_word.sample;
		end
		if (cmd.prod) begin
			old_q  <= ram_rdata;
			full_q <= held_q >= n_eff;
			ysq_q  <= 32'(ym) * 32'(ym);
			osq_q  <= 32'(om) * 32'(om);
			wy_q   <= 24'($signed({1'b0, wmul})) * 24'(y_q);
		end
		if (cmd.calc[0]) begin
			pa_q    <= 36'($signed({1'b0, n_eff})) * 36'(siw_q);
			pb_q    <= 34'($signed({1'b0, tri_n})) * 34'(sv_q);
			dp_q    <= 37'(d_n) * 37'(per_eff);
			qq_q    <= 32'(qs_eff) * 32'(qs_eff);
			rl2_q   <= 32'(rlim_q) * 32'(rlim_q);
			nsq_q   <= 44'(n_eff) * 44'(sq_q);
			vv_q    <= 44'(vm) * 44'(vm);
			vm_q    <= vm;
			svneg_q <= sv_q[21];
			dd_q    <= 42'(d_n) * 42'(d_n);
			dn2_q   <= 34'(d_n) * 34'(nn_n);
		end
		if (cmd.calc[1]) begin
			s_q      <= pa_q - 36'(pb_q);
			var_q    <= (nsq_q > vv_q) ? nsq_q - vv_q : 44'd0;
			slimdp_q <= 53'(slim_q) * 53'(dp_q);
			ddqlo_q  <= 53'(dd_q[20:0]) * 53'(qq_q);
			ddqhi_q  <= 53'(dd_q[41:21]) * 53'(qq_q);
			dn2qq_q  <= 66'(dn2_q) * 66'(qq_q);
			dn2rl_q  <= 66'(dn2_q) * 66'(rl2_q);
		end
		if (cmd.calc[2]) begin
			sneg_q <= s_q[35];
			sm_q   <= s_q[35] ? 32'(-s_q) : 32'(s_q);
			dv_q   <= 65'(var_q) * 65'(d_n);
			ddqq_q <= 74'(ddqlo_q) + {ddqhi_q, 21'd0};
		end
		if (cmd.calc[3]) begin
			a_q  <= 50'(sm_q) * 50'd256000;
			s2_q <= 64'(sm_q) * 64'(sm_q);
		end
		if (cmd.calc[4]) begin
			num_q    <= (dv_q > 65'(s2_q)) ? dv_q - 65'(s2_q) : 65'd0;
			slp_ok_q <= (53'(a_q) <= slimdp_q) || (74'(s2x12) <= ddqq_q);
		end
		if (cmd.calc[5]) begin
			rms_ok_q <= (66'(num_q) <= dn2rl_q) || (numx12 <= 69'(dn2qq_q));
		end
		if (cmd.fin) begin
			srnd_q <= 51'(sdiv_quot) + 51'(38'({sdiv_rem, 1'b0}) >= 38'(dp_q));
			rmse_q <= (|msum[18:17]) ? 16'hFFFF : msum[16:1];
			mean_q <= svneg_q ? 16'(-mmag) : 16'(mmag);
		end
	end

	assign s2x12  = {s2_q, 3'd0} + 68'({s2_q, 2'd0});
	assign numx12 = {num_q, 3'd0} + 69'({num_q, 2'd0});

	srsd_div #(.NUM_W(50), .DEN_W(37)) u_slope_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (a_q),
		.divisor  (dp_q),
		.busy     (sdiv_busy),
		.quot     (sdiv_quot),
		.rem      (sdiv_rem)
	);

	srsd_div #(.NUM_W(67), .DEN_W(34)) u_rmse_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend ({num_q, 2'b00}),
		.divisor  (dn2_q),
		.busy     (rdiv_busy),
		.quot     (rdiv_quot),
		.rem      ()
	);

	srsd_div #(.NUM_W(24), .DEN_W(8)) u_mean_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (24'({vm_q, 1'b0}) + 24'(n_eff)),
		.divisor  ({n_eff, 1'b0}),
		.busy     (mdiv_busy),
		.quot     (mdiv_quot),
		.rem      ()
	);

	assign sts.div_done = !sdiv_busy && !rdiv_busy && !mdiv_busy;
	assign mmag         = mdiv_quot[16:0];

	// Digit-by-digit square root of the saturated quotient, two operand bits per step.
	assign rem_sh = {sq_rem_q[SQ_STEPS:0], sq_op_q[SQ_OP_W-1:SQ_OP_W-2]};
	assign trial  = (SQ_STEPS+3)'({sq_root_q, 2'b01});

	always_ff @(posedge clk) begin
		if (cmd.sq_init) begin
			sq_op_q   <= (|rdiv_quot[66:SQ_OP_W]) ? '1 : rdiv_quot[SQ_OP_W-1:0];
			sq_root_q <= '0;
			sq_rem_q  <= '0;
		end else if (cmd.sq_step) begin
			sq_op_q <= {sq_op_q[SQ_OP_W-3:0], 2'b00};
			if (rem_sh >= trial) begin
				sq_rem_q  <= rem_sh - trial;
				sq_root_q <= {sq_root_q[SQ_STEPS-2:0], 1'b1};
			end else begin
				sq_rem_q  <= rem_sh;
				sq_root_q <= {sq_root_q[SQ_STEPS-2:0], 1'b0};
			end
		end
	end

	assign msum     = 19'(sq_root_q) + 19'd1;
	assign slim_sel = sneg_q ? 51'h0_8000_0000 : 51'h0_7FFF_FFFF;
	assign sval     = (srnd_q > slim_sel) ? slim_sel : srnd_q;

	always_comb begin
		res_next = '0;
		case (cmd.kind)
			KIND_PART: begin
				res_next.fill_count = held_q;
			end
			KIND_FULL: begin
				res_next.steady     = slp_ok_q && rms_ok_q;
				res_next.full_res   = 1'b1;
				res_next.fill_count = held_q;
				res_next.slope      = sneg_q ? 32'(-sval) : 32'(sval);
				res_next.rmse       = rmse_q;
				res_next.mean       = mean_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			res_word <= res_next;
		end
	end

endmodule

// File: hdl/srsd_ctrl.sv
// Controller state machine sequencing the update, fit, division and root steps.
`timescale 1ns / 1ps
module srsd_ctrl import srsd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	input  logic     req_op,
	output logic     req_stall,
	output logic     res_valid,
	input  logic     res_stall,
	input  ctl_sts_t sts,
	output ctl_cmd_t cmd
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_UPD1 = 4'd1;
	localparam logic [3:0] ST_UPD2 = 4'd2;
	localparam logic [3:0] ST_C1   = 4'd3;
	localparam logic [3:0] ST_C2   = 4'd4;
	localparam logic [3:0] ST_C3   = 4'd5;
	localparam logic [3:0] ST_C4   = 4'd6;
	localparam logic [3:0] ST_C5   = 4'd7;
	localparam logic [3:0] ST_C6   = 4'd8;
	localparam logic [3:0] ST_DIVW = 4'd9;
	localparam logic [3:0] ST_SQI  = 4'd10;
	localparam logic [3:0] ST_SQRT = 4'd11;
	localparam logic [3:0] ST_FIN  = 4'd12;
	localparam logic [3:0] ST_EMIT = 4'd13;

	localparam int SCW = $clog2(SQ_STEPS);

	logic [3:0]     state_q, state_d;
	logic [1:0]     kind_q, kind_d;
	logic [SCW-1:0] sq_cnt_q;
	logic           res_valid_q;
	logic           accept, load;

	assign req_stall = state_q != ST_IDLE;
	assign accept    = req_valid && !req_stall;
	assign load      = (state_q == ST_EMIT) && (!res_valid_q || !res_stall);

	always_comb begin
		state_d = state_q;
		kind_d  = kind_q;
		cmd     = '0;
		cmd.kind     = kind_q;
		cmd.load_out = load;
		unique case (state_q)
			ST_IDLE: begin
				cmd.accept = accept;
				if (accept) begin
					if (req_op == OP_CLEAR) begin
						kind_d  = KIND_CLEAR;
						state_d = ST_EMIT;
					end else begin
						state_d = ST_UPD1;
					end
				end
			end
			ST_UPD1: begin
				cmd.prod = 1'b1;
				state_d  = ST_UPD2;
			end
			ST_UPD2: begin
				cmd.update = 1'b1;
				if (sts.will_fill) begin
					state_d = ST_C1;
				end else begin
					kind_d  = KIND_PART;
					state_d = ST_EMIT;
				end
			end
			ST_C1: begin
				cmd.calc[0] = 1'b1;
				state_d     = ST_C2;
			end
			ST_C2: begin
				cmd.calc[1] = 1'b1;
				state_d     = ST_C3;
			end
			ST_C3: begin
				cmd.calc[2] = 1'b1;
				state_d     = ST_C4;
			end
			ST_C4: begin
				cmd.calc[3] = 1'b1;
				state_d     = ST_C5;
			end
			ST_C5: begin
				cmd.calc[4] = 1'b1;
				state_d     = ST_C6;
			end
			ST_C6: begin
				cmd.calc[5]   = 1'b1;
				cmd.div_start = 1'b1;
				state_d       = ST_DIVW;
			end
			ST_DIVW: begin
				if (sts.div_done) begin
					state_d = ST_SQI;
				end
			end
			ST_SQI: begin
				cmd.sq_init = 1'b1;
				state_d     = ST_SQRT;
			end
			ST_SQRT: begin
				cmd.sq_step = 1'b1;
				if (sq_cnt_q == '0) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				cmd.fin = 1'b1;
				kind_d  = KIND_FULL;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kind_q      <= KIND_CLEAR;
			sq_cnt_q    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
			if (state_q == ST_SQI) begin
				sq_cnt_q <= SCW'(SQ_STEPS - 1);
			end else if (state_q == ST_SQRT) begin
				sq_cnt_q <= sq_cnt_q - SCW'(1);
			end
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;

endmodule

// File: hdl/sliding_regression_steady_detector_top.sv
// Top level of the sliding-window least-squares steady-state detector.
// A clear word goes straight to the result register; a push that leaves the window short
// of full passes through the product and update states first; a push on a full window
// also runs the fit, the 67-step residual division and the 18-step square root.
// One word is processed at a time; the next is accepted once the result is registered.
// Reset empties the window and loads the default configuration.
`timescale 1ns / 1ps
module sliding_regression_steady_detector_top import srsd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  req_word_t             req_word,
	output logic                  res_valid,
	input  logic                  res_stall,
	output res_word_t             res_word
);

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	srsd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_op    (req_word.op),
		.req_stall (req_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	srsd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_word  (req_word),
		.cmd       (cmd),
		.sts       (sts),
		.res_word  (res_word)
	);

	// A new result must never overwrite one that is still waiting to be taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !(res_valid && res_stall))
		else $error("result register overwritten while stalled");

	// The dividers must be running in the cycle after they are started.
	a_div_running: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> !sts.div_done)
		else $error("dividers idle after start");

	// Acceptance, product, update and output load are distinct phases.
	a_phases: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.prod, cmd.update, cmd.load_out}))
		else $error("overlapping datapath phases");

endmodule

// File: verif/tb_sliding_regression_steady_detector_top.sv
// Self-checking testbench for the sliding regression steady detector top level.
`timescale 1ns / 1ps
module tb_sliding_regression_steady_detector_top;
	import srsd_pkg::*;

	typedef logic [127:0] u128_t;
	typedef enum logic {ROW_WORD, ROW_REG} row_kind_e;
	typedef struct {
		row_kind_e             kind;
		logic                  op;
		logic [15:0]           smp;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		bit                    pinned;
		res_word_t             res;
	} script_row_t;

	localparam res_word_t NO_RES = '{1'b0, 1'b0, 7'd0, 32'sd0, 16'd0, 16'sd0};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  req_valid = 1'b0;
	logic                  req_stall;
	req_word_t             req_word = '0;
	logic                  res_valid;
	logic                  res_stall = 1'b0;
	res_word_t             res_word;

	// Shadow of the detector: configuration, ring and running sums.
	longint            win_reg, period_reg, slope_lim_reg, rmse_lim_reg, quant_reg;
	logic signed [15:0] ring [WINDOW_MAX];
	longint            wr_ptr, held, sum_y, sum_yy, sum_iy;

	res_word_t   expected_q [$];
	bit          pin_valid = 1'b0;
	res_word_t   pin_res = NO_RES;
	int          errors = 0;
	int          words_sent = 0, results_seen = 0, steady_seen = 0, full_seen = 0;
	int          saturated_seen = 0;
	int          hold_request = 0;

	sliding_regression_steady_detector_top u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .req_valid(req_valid), .req_stall(req_stall),
		.req_word(req_word), .res_valid(res_valid), .res_stall(res_stall),
		.res_word(res_word)
	);

	always #5 clk = ~clk;

	initial begin
		#10_000_000;
		$display("sliding_regression_steady_detector_top verification failed");
		$finish;
	end

	function automatic void empty_window();
		wr_ptr = 0;
		held = 0;
		sum_y = 0;
		sum_yy = 0;
		sum_iy = 0;
	endfunction

	function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
		case (idx)
			CFG_WINDOW_LEN: begin
				win_reg = val[6:0];
				empty_window();
			end
			CFG_PERIOD:      period_reg = val;
			CFG_SLOPE_LIMIT: slope_lim_reg = val;
			CFG_RMSE_LIMIT:  rmse_lim_reg = val;
			CFG_QUANT_STEP:  quant_reg = val;
			default: ;
		endcase
	endfunction

	function automatic res_word_t fit_window(logic op, logic signed [15:0] smp);
		res_word_t r;
		longint n, y, old, s, sm, vm, period, qs, d, lo, hi, mid, t, val;
		u128_t prod, den, q, rem, lim, s2, a, b, t1, resid, dn2;
		bit sneg, slope_ok, rmse_ok;
		r = NO_RES;
		n = (win_reg < 2) ? 2 : ((win_reg > WINDOW_MAX) ? WINDOW_MAX : win_reg);
		if (op == OP_CLEAR) begin
			empty_window();
			return r;
		end
		y = smp;
		if (held >= n) begin
			old = ring[(wr_ptr + WINDOW_MAX - n) % WINDOW_MAX];
			sum_iy = sum_iy - (sum_y - old) + (n - 1) * y;
			sum_y = sum_y - old + y;
			sum_yy = sum_yy - old * old + y * y;
			held = n;
		end else begin
			sum_iy += held * y;
			sum_y += y;
			sum_yy += y * y;
			held++;
		end
		ring[wr_ptr] = smp;
		wr_ptr = (wr_ptr + 1) % WINDOW_MAX;
		r.fill_count = held[6:0];
		if (held < n) return r;
		r.full_res = 1'b1;
		period = (period_reg == 0) ? 1000 : period_reg;
		qs = (quant_reg == 0) ? 16 : quant_reg;
		d = n * n * (n * n - 1) / 12;
		s = n * sum_iy - (n * (n - 1) / 2) * sum_y;
		sneg = s < 0;
		sm = sneg ? -s : s;
		vm = (sum_y < 0) ? -sum_y : sum_y;

		prod = u128_t'(sm) * 256000;
		den = u128_t'(d) * u128_t'(period);
		q = prod / den;
		rem = prod % den;
		if (rem >= den - rem) q++;
		lim = sneg ? 128'h8000_0000 : 128'h7fff_ffff;
		if (q > lim) q = lim;
		r.slope = sneg ? 32'(32'd0 - q[31:0]) : q[31:0];

		s2 = u128_t'(sm) * u128_t'(sm);
		a = u128_t'(n) * u128_t'(sum_yy);
		b = u128_t'(vm) * u128_t'(vm);
		t1 = (a > b) ? a - b : '0;
		t1 = t1 * u128_t'(d);
		resid = (t1 > s2) ? t1 - s2 : '0;
		dn2 = u128_t'(d) * u128_t'(n * n);
		lo = 0;
		hi = 65535;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			t = 2 * mid - 1;
			if (dn2 * u128_t'(t * t) <= resid * 4) lo = mid;
			else hi = mid - 1;
		end
		r.rmse = lo[15:0];
		val = (2 * vm + n) / (2 * n);
		r.mean = (sum_y < 0) ? 16'(-val) : 16'(val);

		slope_ok = (prod <= u128_t'(slope_lim_reg) * u128_t'(d) * u128_t'(period)) ||
			(s2 * 12 <= u128_t'(d) * u128_t'(d) * u128_t'(qs * qs));
		rmse_ok = (resid <= dn2 * u128_t'(rmse_lim_reg * rmse_lim_reg)) ||
			(resid * 12 <= dn2 * u128_t'(qs * qs));
		r.steady = slope_ok && rmse_ok;
		return r;
	endfunction

	task automatic report(string what, longint got, longint want);
		errors++;
		$display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
	endtask

	// Track accepted words and register writes; the expectation is worked out on acceptance.
	always @(posedge clk) begin
		res_word_t r;
		if (arst_n) begin
			if (cfg_we) apply_register(cfg_index, cfg_data);
			if (req_valid && !req_stall) begin
				r = fit_window(req_word.op, req_word.sample);
				expected_q.push_back(pin_valid ? pin_res : r);
			end
		end
	end

	always @(posedge clk) begin
		res_word_t e;
		if (arst_n && res_valid && !res_stall) begin
			results_seen++;
			if (expected_q.size() == 0) begin
				report("unexpected result word", 1, 0);
			end else begin
				e = expected_q[0];
				expected_q.delete(0);
				if (res_word.steady != e.steady) report("steady", res_word.steady, e.steady);
				if (res_word.full_res != e.full_res)
					report("full_res", res_word.full_res, e.full_res);
				if (res_word.fill_count != e.fill_count)
					report("fill_count", res_word.fill_count, e.fill_count);
				if (res_word.slope != e.slope) report("slope", res_word.slope, e.slope);
				if (res_word.rmse != e.rmse) report("rmse", res_word.rmse, e.rmse);
				if (res_word.mean != e.mean) report("mean", res_word.mean, e.mean);
				if (e.steady) steady_seen++;
				if (e.full_res) full_seen++;
				if (e.slope == 32'sh7fff_ffff || e.slope == -32'sh8000_0000 || e.rmse == 16'hffff)
					saturated_seen++;
			end
		end
	end

	// Receiver: randomly chosen stretches of no stall, light stall and heavy stall.
	initial begin
		int seg_len, seg_mode, hold_left;
		hold_left = 0;
		seg_len = 0;
		seg_mode = 0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_stall = 1'b1;
			end else begin
				if (seg_len == 0) begin
					seg_len = $urandom_range(20, 300);
					seg_mode = $urandom_range(0, 2);
				end
				seg_len--;
				case (seg_mode)
					0: res_stall = 1'b0;
					1: res_stall = ($urandom_range(0, 3) == 0);
					default: res_stall = ($urandom_range(0, 9) < 7);
				endcase
			end
		end
	end

	task automatic sender_gap();
		int gap;
		case ($urandom_range(0, 19))
			0:       gap = $urandom_range(20, 80);
			1, 2, 3: gap = $urandom_range(1, 4);
			default: gap = 0;
		endcase
		if (gap > 0) begin
			req_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic send_word(logic op, logic [15:0] smp, bit pinned, res_word_t pres);
		req_valid = 1'b1;
		req_word.op = op;
		req_word.sample = smp;
		pin_valid = pinned;
		pin_res = pres;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
		words_sent++;
	endtask

	task automatic wait_drained();
		req_valid = 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	initial begin
		script_row_t script [$];
		int base, amp, slope_step, style, waited;
		logic [15:0] smp;
		longint v;

		win_reg = 32;
		period_reg = 1000;
		slope_lim_reg = 0;
		rmse_lim_reg = 0;
		quant_reg = 16;
		for (int i = 0; i < WINDOW_MAX; i++) ring[i] = '0;
		empty_window();

		script.push_back('{ROW_WORD, OP_CLEAR, 16'h1234, 3'd0, 16'd0, 1'b1, NO_RES});
		script.push_back('{ROW_WORD, OP_PUSH, 16'h7fff, 3'd0, 16'd0, 1'b1,
			'{1'b0, 1'b0, 7'd1, 32'sd0, 16'd0, 16'sd0}});
		script.push_back('{ROW_WORD, OP_PUSH, 16'h8000, 3'd0, 16'd0, 1'b1,
			'{1'b0, 1'b0, 7'd2, 32'sd0, 16'd0, 16'sd0}});
		script.push_back('{ROW_REG, OP_PUSH, 16'h0, CFG_WINDOW_LEN, 16'd2, 1'b0, NO_RES});
		script.push_back('{ROW_WORD, OP_PUSH, 16'h8000, 3'd0, 16'd0, 1'b1,
			'{1'b0, 1'b0, 7'd1, 32'sd0, 16'd0, 16'sd0}});
		script.push_back('{ROW_WORD, OP_PUSH, 16'h7fff, 3'd0, 16'd0, 1'b0, NO_RES});
		script.push_back('{ROW_WORD, OP_PUSH, 16'h7fff, 3'd0, 16'd0, 1'b0, NO_RES});
		script.push_back('{ROW_WORD, OP_PUSH, 16'h7fff, 3'd0, 16'd0, 1'b0, NO_RES});
		script.push_back('{ROW_WORD, OP_CLEAR, 16'hffff, 3'd0, 16'd0, 1'b1, NO_RES});
		script.push_back('{ROW_WORD, OP_PUSH, 16'h0000, 3'd0, 16'd0, 1'b1,
			'{1'b0, 1'b0, 7'd1, 32'sd0, 16'd0, 16'sd0}});
		script.push_back('{ROW_REG, OP_PUSH, 16'h0, CFG_WINDOW_LEN, 16'd0, 1'b0, NO_RES});
		script.push_back('{ROW_WORD, OP_PUSH, 16'd100, 3'd0, 16'd0, 1'b0, NO_RES});
		script.push_back('{ROW_WORD, OP_PUSH, 16'd100, 3'd0, 16'd0, 1'b0, NO_RES});
		script.push_back('{ROW_REG, OP_PUSH, 16'h0, CFG_QUANT_STEP, 16'd0, 1'b0, NO_RES});
		script.push_back('{ROW_REG, OP_PUSH, 16'h0, CFG_PERIOD, 16'd0, 1'b0, NO_RES});
		script.push_back('{ROW_WORD, OP_PUSH, 16'd101, 3'd0, 16'd0, 1'b0, NO_RES});
		script.push_back('{ROW_REG, OP_PUSH, 16'h0, CFG_WINDOW_LEN, 16'd3, 1'b0, NO_RES});
		script.push_back('{ROW_REG, OP_PUSH, 16'h0, CFG_PERIOD, 16'd1, 1'b0, NO_RES});
		script.push_back('{ROW_REG, OP_PUSH, 16'h0, CFG_SLOPE_LIMIT, 16'hffff, 1'b0, NO_RES});
		script.push_back('{ROW_REG, OP_PUSH, 16'h0, CFG_RMSE_LIMIT, 16'hffff, 1'b0, NO_RES});
		script.push_back('{ROW_WORD, OP_PUSH, 16'h8000, 3'd0, 16'd0, 1'b0, NO_RES});
		script.push_back('{ROW_WORD, OP_PUSH, 16'h7fff, 3'd0, 16'd0, 1'b0, NO_RES});
		script.push_back('{ROW_WORD, OP_PUSH, 16'h8000, 3'd0, 16'd0, 1'b0, NO_RES});
		script.push_back('{ROW_WORD, OP_PUSH, 16'h7fff, 3'd0, 16'd0, 1'b0, NO_RES});
		script.push_back('{ROW_WORD, OP_PUSH, 16'h7ffe, 3'd0, 16'd0, 1'b0, NO_RES});

		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (script[i]) begin
			if (script[i].kind == ROW_REG) begin
				wait_drained();
				write_register(script[i].idx, script[i].data);
			end else begin
				sender_gap();
				send_word(script[i].op, script[i].smp, script[i].pinned, script[i].res);
			end
		end
		pin_valid = 1'b0;

		for (int phase = 0; phase < 12; phase++) begin
			wait_drained();
			case (phase % 6)
				0: v = 64;
				1: v = 2;
				2: v = 127;
				3: v = $urandom_range(0, 1);
				4: v = $urandom_range(3, 16);
				default: v = $urandom_range(0, 127);
			endcase
			write_register(CFG_WINDOW_LEN, 16'(v));
			case ($urandom_range(0, 4))
				0: v = 1;
				1: v = 65535;
				2: v = 0;
				3: v = 1000;
				default: v = $urandom_range(0, 65535);
			endcase
			write_register(CFG_PERIOD, 16'(v));
			write_register(CFG_SLOPE_LIMIT, ($urandom_range(0, 3) == 0) ? 16'hffff :
				(($urandom_range(0, 2) == 0) ? 16'h0 : 16'($urandom_range(0, 65535))));
			write_register(CFG_RMSE_LIMIT, ($urandom_range(0, 3) == 0) ? 16'hffff :
				(($urandom_range(0, 2) == 0) ? 16'h0 : 16'($urandom_range(0, 400))));
			write_register(CFG_QUANT_STEP, ($urandom_range(0, 4) == 0) ? 16'hffff :
				(($urandom_range(0, 3) == 0) ? 16'h0 : 16'($urandom_range(1, 64))));

			base = $urandom_range(0, 65535) - 32768;
			amp = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 200);
			slope_step = $urandom_range(0, 40) - 20;
			style = $urandom_range(0, 2);
			for (int k = 0; k < 50; k++) begin
				if (phase == 3 && k == 10) hold_request = 400;
				if (phase == 7 && k == 25) wait_drained();
				sender_gap();
				v = base;
				if (style == 1) v = base + k * slope_step;
				v = v + $urandom_range(0, 2 * amp) - amp;
				if ($urandom_range(0, 9) == 0) v = $urandom_range(0, 65535) - 32768;
				if (v > 32767) v = 32767;
				if (v < -32768) v = -32768;
				smp = 16'(v);
				if (style == 2 && $urandom_range(0, 3) == 0) smp = $urandom_range(0, 65535);
				send_word(($urandom_range(0, 39) == 0) ? OP_CLEAR : OP_PUSH, smp, 1'b0, NO_RES);
			end
		end

		req_valid = 1'b0;
		waited = 0;
		while (expected_q.size() != 0 && waited < 100000) begin
			@(negedge clk);
			waited++;
		end
		repeat (200) @(negedge clk);
		if (expected_q.size() != 0) report("results still outstanding", expected_q.size(), 0);
		$display("Run covered %0d words and %0d results: %0d with a full window, %0d steady,",
			words_sent, results_seen, full_seen, steady_seen);
		$display("%0d saturated, across window lengths 2 to 64 and register extremes.",
			saturated_seen);
		if (errors == 0) begin
			$display("sliding_regression_steady_detector_top verification clean");
		end else begin
			$display("sliding_regression_steady_detector_top verification failed");
		end
		$finish;
	end

endmodule

// File: filelist.f
hdl/srsd_pkg.sv
hdl/srsd_ram.sv
hdl/srsd_div.sv
hdl/srsd_dp.sv
hdl/srsd_ctrl.sv
hdl/sliding_regression_steady_detector_top.sv
verif/tb_sliding_regression_steady_detector_top.sv
